@@ design/pwt_pkg.sv @@
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared types and constants for the wire-format tokenizer.
// ----------------------------------------------------------------------------
package pwt_pkg;

	localparam logic [63:0] LENGTH_LIMIT = 64'd65535;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_KEY,
		PH_VARINT,
		PH_FIXED,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_DROP
	} phase_t;

	typedef enum logic [2:0] {
		TK_VARINT  = 3'd0,
		TK_FIXED64 = 3'd1,
		TK_LENGTH  = 3'd2,
		TK_FIXED32 = 3'd3,
		TK_PAYLOAD = 3'd4,
		TK_END_OK  = 3'd5,
		TK_ERROR   = 3'd6
	} tok_kind_t;

	typedef enum logic [1:0] {
		EC_NONE      = 2'd0,
		EC_TRUNCATED = 2'd1,
		EC_BAD_WIRE  = 2'd2,
		EC_OVERLONG  = 2'd3
	} err_cause_t;

	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LENGTH  = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	typedef struct packed {
		tok_kind_t  kind;
		logic [31:0] field;
		logic [2:0]  wtype;
		logic [63:0] value;
		err_cause_t  cause;
		logic        last;
	} token_t;

	// Up to two tokens produced by one byte
	typedef struct packed {
		logic   has_a;
		logic   has_b;
		token_t a;
		token_t b;
	} pair_t;

endpackage

@@ design/protobuf_wire_tokenizer.sv @@
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer
// Protocol-buffer wire-format tokenizer, one message byte per transaction.
// ----------------------------------------------------------------------------
// Input channel: drive data_byte and end_of_buffer with push; a transaction
// completes on a clock edge with push high and full low. Mark the last byte of
// each message with end_of_buffer.
// Output channel: while empty is low the oldest token sits on the token ports;
// pulse pop to take it. run_last flags the final token caused by one byte.
// Each byte gives zero, one or two tokens (a value or payload token, then an
// end token on the last byte or an error token). A byte is taken every cycle
// while the token queue has room; its tokens are written into the queue as
// the byte is taken. Throughput is one byte and one token per cycle, so bytes
// that give two tokens fill the four-entry queue and full rises when pop lags.
// If the receiver stalls, tokens wait in the queue and full holds off input.
// After an error, bytes up to the message's last are dropped without tokens.
// Reset clears the queue and sets the parser to expect a field key.
// ----------------------------------------------------------------------------
module protobuf_wire_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  token_kind,
	output logic [31:0] field_number,
	output logic [2:0]  wire_kind,
	output logic [63:0] field_value,
	output logic [1:0]  error_cause,
	output logic        run_last
);
	import pwt_pkg::*;

	pair_t  wr_pair;
	pair_t  head_pair;
	token_t tok;
	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_empty;

	pwt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_buffer(end_of_buffer),
		.q_push       (q_push),
		.q_full       (q_full),
		.q_data       (wr_pair)
	);

	pwt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(wr_pair),
		.q_full (q_full),
		.rd_en  (q_pop),
		.rd_data(head_pair),
		.q_empty(q_empty)
	);

	pwt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_pair),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.token  (tok)
	);

	assign token_kind   = tok.kind;
	assign field_number = tok.field;
	assign wire_kind    = tok.wtype;
	assign field_value  = tok.value;
	assign error_cause  = tok.cause;
	assign run_last     = tok.last;

endmodule

@@ design/pwt_front.sv @@
// ----------------------------------------------------------------------------
// pwt_front
// Byte parser: tracks the field state and turns each byte into up to two tokens.
// ----------------------------------------------------------------------------
module pwt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    data_byte,
	input  logic          end_of_buffer,
	output logic          q_push,
	input  logic          q_full,
	output pwt_pkg::pair_t q_data
);
	import pwt_pkg::*;

	phase_t      phase_q, ph_n;
	logic [63:0] acc_q, acc_n;
	logic [3:0]  idx_q, idx_n;
	logic [31:0] fld_q, fld_n;
	logic [2:0]  wire_q, wire_n;
	logic [15:0] left_q, left_n;

	logic        accept;
	logic [3:0]  idx_c;
	logic [5:0]  vshift;
	logic [63:0] vpiece;
	logic [63:0] vacc;
	logic        vdone;
	logic        vover;
	logic [2:0]  fidx;
	logic [63:0] facc;
	logic [3:0]  fcnt;
	logic [3:0]  fneed;
	logic [15:0] left_d;
	logic        go_key;
	err_cause_t  err;
	pair_t       pr;

	assign full   = q_full;
	assign accept = push && !q_full;

	always_comb begin
		idx_c  = (idx_q > 4'd9) ? 4'd9 : idx_q;
		vshift = {2'b00, idx_c} * 6'd7;
		vpiece = {57'd0, data_byte[6:0]} << vshift;
		vacc   = acc_q | vpiece;
		vdone  = !data_byte[7];
		vover  = data_byte[7] && (idx_c == 4'd9);
		fidx   = idx_q[2:0];
		facc   = acc_q | ({56'd0, data_byte} << {fidx, 3'b000});
		fcnt   = {1'b0, fidx} + 4'd1;
		fneed  = (wire_q == WT_FIXED64) ? 4'd8 : 4'd4;
		left_d = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;
	end

	always_comb begin
		ph_n   = phase_q;
		acc_n  = acc_q;
		idx_n  = idx_q;
		fld_n  = fld_q;
		wire_n = wire_q;
		left_n = left_q;
		go_key = 1'b0;
		err    = EC_NONE;
		pr     = '0;

		case (phase_q)
			PH_DROP: begin
				if (end_of_buffer) go_key = 1'b1;
			end
			PH_KEY: begin
				if (vover) begin
					err = EC_OVERLONG;
				end else if (vdone) begin
					fld_n  = vacc[34:3];
					wire_n = vacc[2:0];
					acc_n  = '0;
					idx_n  = '0;
					case (vacc[2:0])
						WT_VARINT:  ph_n = PH_VARINT;
						WT_FIXED64: ph_n = PH_FIXED;
						WT_FIXED32: ph_n = PH_FIXED;
						WT_LENGTH:  ph_n = PH_LENGTH;
						default:    err  = EC_BAD_WIRE;
					endcase
				end else begin
					acc_n = vacc;
					idx_n = idx_c + 4'd1;
				end
			end
			PH_VARINT: begin
				if (vover) begin
					err = EC_OVERLONG;
				end else if (vdone) begin
					pr.has_a   = 1'b1;
					pr.a.kind  = TK_VARINT;
					pr.a.field = fld_q;
					pr.a.wtype = wire_q;
					pr.a.value = vacc;
					go_key     = 1'b1;
				end else begin
					acc_n = vacc;
					idx_n = idx_c + 4'd1;
				end
			end
			PH_FIXED: begin
				if (fcnt >= fneed) begin
					pr.has_a   = 1'b1;
					pr.a.kind  = (fneed == 4'd8) ? TK_FIXED64 : TK_FIXED32;
					pr.a.field = fld_q;
					pr.a.wtype = wire_q;
					pr.a.value = facc;
					go_key     = 1'b1;
				end else begin
					acc_n = facc;
					idx_n = fcnt;
				end
			end
			PH_LENGTH: begin
				if (vover) begin
					err = EC_OVERLONG;
				end else if (vdone) begin
					if (vacc > LENGTH_LIMIT) begin
						err = EC_OVERLONG;
					end else begin
						pr.has_a   = 1'b1;
						pr.a.kind  = TK_LENGTH;
						pr.a.field = fld_q;
						pr.a.wtype = wire_q;
						pr.a.value = vacc;
						if (vacc == 64'd0) begin
							go_key = 1'b1;
						end else begin
							left_n = vacc[15:0];
							acc_n  = '0;
							idx_n  = '0;
							ph_n   = PH_PAYLOAD;
						end
					end
				end else begin
					acc_n = vacc;
					idx_n = idx_c + 4'd1;
				end
			end
			default: begin
				pr.has_a   = 1'b1;
				pr.a.kind  = TK_PAYLOAD;
				pr.a.field = fld_q;
				pr.a.wtype = wire_q;
				pr.a.value = {56'd0, data_byte};
				left_n     = left_d;
				if (left_d == 16'd0) go_key = 1'b1;
			end
		endcase

		if (phase_q != PH_DROP) begin
			if (err == EC_NONE && end_of_buffer) begin
				if (go_key || (ph_n == PH_KEY && idx_n == 4'd0)) begin
					pr.has_b  = 1'b1;
					pr.b.kind = TK_END_OK;
				end else begin
					err = EC_TRUNCATED;
				end
			end
			if (err != EC_NONE) begin
				pr.has_b   = 1'b1;
				pr.b.kind  = TK_ERROR;
				pr.b.field = fld_n;
				pr.b.wtype = wire_n;
				pr.b.cause = err;
			end
			if (err != EC_NONE || end_of_buffer) go_key = 1'b1;
		end

		pr.a.last = !pr.has_b;
		pr.b.last = 1'b1;

		if (go_key) begin
			ph_n   = PH_KEY;
			acc_n  = '0;
			idx_n  = '0;
			fld_n  = '0;
			wire_n = '0;
			left_n = '0;
		end
		if (phase_q != PH_DROP && err != EC_NONE && !end_of_buffer) ph_n = PH_DROP;
	end

	assign q_push = accept && (pr.has_a || pr.has_b);
	assign q_data = pr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			acc_q   <= '0;
			idx_q   <= '0;
			fld_q   <= '0;
			wire_q  <= '0;
			left_q  <= '0;
		end else if (accept) begin
			phase_q <= ph_n;
			acc_q   <= acc_n;
			idx_q   <= idx_n;
			fld_q   <= fld_n;
			wire_q  <= wire_n;
			left_q  <= left_n;
		end
	end

endmodule

@@ design/pwt_queue.sv @@
// ----------------------------------------------------------------------------
// pwt_queue
// Short queue of token pairs between the parser and the output side.
// ----------------------------------------------------------------------------
module pwt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  pwt_pkg::pair_t wr_data,
	output logic           q_full,
	input  logic           rd_en,
	output pwt_pkg::pair_t rd_data,
	output logic           q_empty
);
	import pwt_pkg::*;

	pair_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_wr;
	logic               do_rd;

	assign q_full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = slots_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) slots_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_rd) rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/pwt_back.sv @@
// ----------------------------------------------------------------------------
// pwt_back
// Output side: unpacks each queued pair into one token per transaction.
// ----------------------------------------------------------------------------
module pwt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pwt_pkg::pair_t head,
	input  logic           q_empty,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output pwt_pkg::token_t token
);
	import pwt_pkg::*;

	logic second_q;
	logic use_b;
	logic final_tok;
	logic take;

	assign use_b     = second_q || !head.has_a;
	assign final_tok = use_b || !head.has_b;
	assign token     = use_b ? head.b : head.a;
	assign empty     = q_empty;
	assign take      = pop && !q_empty;
	assign q_pop     = take && final_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (take) begin
			second_q <= !final_tok;
		end
	end

endmodule

@@ dv/pwt_token_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwt_token_checker
// Passive checker for the wire-format tokenizer. It samples both queue sides
// at the rising edge, runs its own copy of the parser on every byte
// transaction, and compares each popped token, field by field, with the
// oldest predicted token.
// ----------------------------------------------------------------------------
module pwt_token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  token_kind,
	input  logic [31:0] field_number,
	input  logic [2:0]  wire_kind,
	input  logic [63:0] field_value,
	input  logic [1:0]  error_cause,
	input  logic        run_last,
	output int          fails,
	output int          waiting,
	output int          live_bytes,
	output int          tokens_checked,
	output int          error_tokens
);
	import pwt_pkg::*;

	phase_t      phase;
	logic [63:0] acc;
	logic [3:0]  idx;
	logic [31:0] fld;
	logic [2:0]  wt;
	logic [15:0] left;
	token_t      tokens_due[$];
	token_t      seen;
	token_t      due;

	task automatic rearm();
		phase = PH_KEY;
		acc = '0;
		idx = '0;
		fld = '0;
		wt = '0;
		left = '0;
	endtask

	task automatic note_token(input tok_kind_t k, input logic [31:0] f, input logic [2:0] w,
			input logic [63:0] v, input err_cause_t c);
		token_t t;
		t.kind = k;
		t.field = f;
		t.wtype = w;
		t.value = v;
		t.cause = c;
		t.last = 1'b0;
		tokens_due.push_back(t);
	endtask

	// status: 0 more bytes, 1 complete, 2 overlong
	task automatic varint_take(input logic [7:0] b, output int status);
		int unsigned i;
		i = (idx > 4'd9) ? 9 : idx;
		acc = acc | ({57'd0, b[6:0]} << (7 * i));
		if (!b[7]) begin
			status = 1;
		end else begin
			idx = 4'(i + 1);
			status = (idx >= 4'd10) ? 2 : 0;
		end
	endtask

	task automatic advance_parser(input logic [7:0] b, input logic last);
		int         st;
		int         before_n;
		int         need;
		err_cause_t err;
		token_t     t;
		before_n = tokens_due.size();
		err = EC_NONE;
		if (phase == PH_DROP) begin
			if (last)
				rearm();
			return;
		end
		live_bytes++;
		case (phase)
			PH_KEY: begin
				varint_take(b, st);
				if (st == 2) begin
					err = EC_OVERLONG;
				end else if (st == 1) begin
					fld = acc[34:3];
					wt = acc[2:0];
					acc = '0;
					idx = '0;
					if (wt == WT_VARINT)
						phase = PH_VARINT;
					else if (wt == WT_FIXED64 || wt == WT_FIXED32)
						phase = PH_FIXED;
					else if (wt == WT_LENGTH)
						phase = PH_LENGTH;
					else
						err = EC_BAD_WIRE;
				end
			end
			PH_VARINT: begin
				varint_take(b, st);
				if (st == 2) begin
					err = EC_OVERLONG;
				end else if (st == 1) begin
					note_token(TK_VARINT, fld, wt, acc, EC_NONE);
					rearm();
				end
			end
			PH_FIXED: begin
				need = (wt == WT_FIXED64) ? 8 : 4;
				acc = acc | ({56'd0, b} << (8 * idx[2:0]));
				idx = idx[2:0] + 4'd1;
				if (idx >= need) begin
					note_token((need == 8) ? TK_FIXED64 : TK_FIXED32, fld, wt, acc, EC_NONE);
					rearm();
				end
			end
			PH_LENGTH: begin
				varint_take(b, st);
				if (st == 2) begin
					err = EC_OVERLONG;
				end else if (st == 1) begin
					if (acc > LENGTH_LIMIT) begin
						err = EC_OVERLONG;
					end else begin
						note_token(TK_LENGTH, fld, wt, acc, EC_NONE);
						if (acc == 64'd0) begin
							rearm();
						end else begin
							left = acc[15:0];
							acc = '0;
							idx = '0;
							phase = PH_PAYLOAD;
						end
					end
				end
			end
			default: begin
				note_token(TK_PAYLOAD, fld, wt, {56'd0, b}, EC_NONE);
				if (left > 16'd0)
					left = left - 16'd1;
				if (left == 16'd0)
					rearm();
			end
		endcase
		if (err == EC_NONE && last) begin
			if (phase == PH_KEY && idx == 4'd0)
				note_token(TK_END_OK, 32'd0, 3'd0, 64'd0, EC_NONE);
			else
				err = EC_TRUNCATED;
		end
		if (err != EC_NONE) begin
			note_token(TK_ERROR, fld, wt, 64'd0, err);
			rearm();
			if (!last)
				phase = PH_DROP;
		end else if (last) begin
			rearm();
		end
		if (tokens_due.size() > before_n) begin
			t = tokens_due.pop_back();
			t.last = 1'b1;
			tokens_due.push_back(t);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rearm();
			tokens_due.delete();
			fails = 0;
			waiting = 0;
			live_bytes = 0;
			tokens_checked = 0;
			error_tokens = 0;
		end else begin
			if (pop && !empty) begin
				seen.kind = tok_kind_t'(token_kind);
				seen.field = field_number;
				seen.wtype = wire_kind;
				seen.value = field_value;
				seen.cause = err_cause_t'(error_cause);
				seen.last = run_last;
				tokens_checked++;
				if (seen.kind == TK_ERROR)
					error_tokens++;
				if (tokens_due.size() == 0) begin
					fails++;
					$display("%0t: unexpected token kind %0d field %0d wire %0d value %h cause %0d last %b",
						$time, seen.kind, seen.field, seen.wtype, seen.value, seen.cause,
						seen.last);
				end else begin
					due = tokens_due.pop_front();
					if (seen !== due) begin
						fails++;
						$display("%0t: token mismatch, expected kind %0d field %0d wire %0d value %h cause %0d last %b",
							$time, due.kind, due.field, due.wtype, due.value, due.cause,
							due.last);
						$display("%0t: token mismatch, actual   kind %0d field %0d wire %0d value %h cause %0d last %b",
							$time, seen.kind, seen.field, seen.wtype, seen.value, seen.cause,
							seen.last);
					end
				end
			end
			if (push && !full)
				advance_parser(data_byte, end_of_buffer);
			waiting = tokens_due.size();
		end
	end

endmodule

@@ dv/protobuf_wire_tokenizer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer_tb
// Drives encoded messages into the tokenizer byte by byte: a short directed
// set, then random messages that are mostly well formed, mixed with truncated
// messages, bad fields and noise. Both sides idle at random; the checker
// predicts and compares every token, and this module gives the verdict.
// ----------------------------------------------------------------------------
module protobuf_wire_tokenizer_tb;
	import pwt_pkg::*;

	localparam int ITEM_TARGET  = 1450;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 12;
	localparam int GAP_MAX      = 12;

	localparam logic [2:0] WT_START_GROUP = 3'd3;
	localparam logic [2:0] WT_END_GROUP   = 3'd4;
	localparam logic [2:0] WT_RESERVED6   = 3'd6;
	localparam logic [2:0] WT_RESERVED7   = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_buffer = 1'b0;
	logic        full;
	logic        empty;
	logic [2:0]  token_kind;
	logic [31:0] field_number;
	logic [2:0]  wire_kind;
	logic [63:0] field_value;
	logic [1:0]  error_cause;
	logic        run_last;

	int fails;
	int waiting;
	int live_bytes;
	int tokens_checked;
	int error_tokens;
	int cycles = 0;
	int msg_count = 0;
	int push_burst = 0;
	int pop_burst = 0;
	int pick;
	int n;
	logic [7:0] msg[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	protobuf_wire_tokenizer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_buffer(end_of_buffer),
		.empty(empty),
		.pop(pop),
		.token_kind(token_kind),
		.field_number(field_number),
		.wire_kind(wire_kind),
		.field_value(field_value),
		.error_cause(error_cause),
		.run_last(run_last)
	);

	pwt_token_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_buffer(end_of_buffer),
		.empty(empty),
		.pop(pop),
		.token_kind(token_kind),
		.field_number(field_number),
		.wire_kind(wire_kind),
		.field_value(field_value),
		.error_cause(error_cause),
		.run_last(run_last),
		.fails(fails),
		.waiting(waiting),
		.live_bytes(live_bytes),
		.tokens_checked(tokens_checked),
		.error_tokens(error_tokens)
	);

	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 40) == 0)
			burst = $urandom_range(16, 64);
		return $urandom_range(0, GAP_MAX);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = draw_gap(push_burst);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		end_of_buffer <= last;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	task automatic send_message();
		int i;
		msg_count++;
		for (i = 0; i < msg.size(); i++)
			send_byte(msg[i], i == msg.size() - 1);
		msg.delete();
	endtask

	task automatic put_varint(input logic [63:0] v, input int pad);
		int          len;
		int          total;
		int          i;
		logic [63:0] rest;
		logic [7:0]  b;
		len = 1;
		rest = v >> 7;
		while (rest != 64'd0) begin
			len++;
			rest = rest >> 7;
		end
		total = (len + pad > 10) ? 10 : len + pad;
		for (i = 0; i < total; i++) begin
			rest = v >> (7 * i);
			b = {1'b0, rest[6:0]};
			if (i < total - 1)
				b[7] = 1'b1;
			msg.push_back(b);
		end
	endtask

	task automatic put_random_bytes(input int count, input logic cont);
		int         i;
		logic [7:0] b;
		for (i = 0; i < count; i++) begin
			b = 8'($urandom_range(0, 255));
			if (cont)
				b[7] = 1'b1;
			msg.push_back(b);
		end
	endtask

	function automatic logic [31:0] pick_field();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 32'($urandom_range(1, 15));
		if (r < 8)
			return 32'($urandom_range(16, 65535));
		if (r == 8)
			return $urandom;
		return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
	endfunction

	function automatic logic [63:0] pick_value();
		if ($urandom_range(0, 15) == 0)
			return '1;
		return {$urandom, $urandom} >> $urandom_range(0, 63);
	endfunction

	task automatic put_key(input logic [31:0] f, input logic [2:0] w);
		logic [63:0] key;
		logic [63:0] hi;
		key = {29'd0, f, w};
		hi = {$urandom, $urandom};
		if ($urandom_range(0, 15) == 0)
			key[63:35] = hi[28:0];
		put_varint(key, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
	endtask

	task automatic add_field();
		logic [2:0] w;
		int         len;
		case ($urandom_range(0, 3))
			0: w = WT_VARINT;
			1: w = WT_FIXED64;
			2: w = WT_LENGTH;
			default: w = WT_FIXED32;
		endcase
		put_key(pick_field(), w);
		if (w == WT_VARINT) begin
			if ($urandom_range(0, 7) == 0) begin
				// tenth byte ends the varint; its upper bits fall off
				put_random_bytes(9, 1'b1);
				msg.push_back({1'b0, 7'($urandom_range(0, 127))});
			end else begin
				put_varint(pick_value(), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0);
			end
		end else if (w == WT_FIXED64) begin
			put_random_bytes(8, 1'b0);
		end else if (w == WT_FIXED32) begin
			put_random_bytes(4, 1'b0);
		end else begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 5);
			put_varint(64'(len), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
			put_random_bytes(len, 1'b0);
		end
	endtask

	task automatic add_bad_field();
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 3))
					0: put_key(pick_field(), WT_START_GROUP);
					1: put_key(pick_field(), WT_END_GROUP);
					2: put_key(pick_field(), WT_RESERVED6);
					default: put_key(pick_field(), WT_RESERVED7);
				endcase
			end
			1: put_random_bytes(10, 1'b1);
			2: begin
				put_key(pick_field(), WT_VARINT);
				put_random_bytes(10, 1'b1);
			end
			default: begin
				put_key(pick_field(), WT_LENGTH);
				v = ($urandom_range(0, 1) == 0) ? LENGTH_LIMIT + 64'd1 : pick_value();
				put_varint(v | 64'h1_0000, 0);
			end
		endcase
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens still expected", cycles, waiting);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(pop_burst);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
			@(negedge clk);
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		msg = '{8'h08, 8'h96, 8'h01};
		send_message();
		msg = '{8'h0D, 8'h01, 8'h02, 8'h03, 8'h04};
		send_message();
		msg = '{8'h09, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_message();
		msg = '{8'h12, 8'h00, 8'h1A, 8'h02, 8'hAA, 8'h55};
		send_message();
		msg = '{8'h0B, 8'h77};
		send_message();
		msg = '{8'h08};
		send_message();
		msg = '{8'h12, 8'h80, 8'h80, 8'h04};
		send_message();
		msg = '{8'h80};
		send_message();

		while (live_bytes < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				repeat ($urandom_range(1, 4)) add_field();
			end else if (pick < 77) begin
				repeat ($urandom_range(1, 3)) add_field();
				if (msg.size() > 1) begin
					n = $urandom_range(1, msg.size() - 1);
					msg = msg[0:msg.size() - 1 - n];
				end
			end else if (pick < 89) begin
				repeat ($urandom_range(0, 2)) add_field();
				add_bad_field();
				put_random_bytes($urandom_range(0, 6), 1'b0);
			end else if (pick < 95) begin
				put_random_bytes($urandom_range(1, 8), 1'b0);
			end else begin
				put_key(pick_field(), WT_LENGTH);
				put_varint($urandom_range(0, 1) ? LENGTH_LIMIT : 64'($urandom_range(256, 65535)), 0);
				put_random_bytes($urandom_range(0, 5), 1'b0);
			end
			send_message();
		end
		push <= 1'b0;

		wait (waiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d parsed bytes in %0d messages, directed and random, with idling on both sides",
			live_bytes, msg_count);
		$display("checked %0d tokens, %0d of them error tokens", tokens_checked, error_tokens);
		if (fails == 0 && waiting == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
